/* hdl/ddn_pkg.sv */
// ddn_pkg: constants, mode codes and inter-stage structs of the date / day number converter
// no dependencies; used by ddn_split, ddn_yearday, ddn_assemble, the top level and the bench
`default_nettype none

package ddn_pkg;

    // conversion modes
    localparam logic [1:0] MODE_EXACT   = 2'd0;
    localparam logic [1:0] MODE_APPROX  = 2'd1;
    localparam logic [1:0] MODE_TO_DATE = 2'd2;

    // reciprocal constants for division by constants
    // value / 100   = (value * RECIP_100_V) >> 34, exact below 2**30
    localparam logic [27:0] RECIP_100_V   = 28'd171798692;
    // q / 100       = (q * RECIP_100_Q) >> 28, exact below 6.1e6
    localparam logic [21:0] RECIP_100_Q   = 22'd2684355;
    // days / 365    = (days * RECIP_365) >> 28, exact below 1.8e6
    localparam logic [19:0] RECIP_365     = 20'd735440;
    // k / 100       = (k * RECIP_100_K) >> 21, exact below 43690
    localparam logic [14:0] RECIP_100_K   = 15'd20972;

    localparam logic [13:0] EPOCH_YEAR    = 14'd1900;
    localparam logic [26:0] APPROX_LOW    = 27'd19000101;
    localparam logic [26:0] APPROX_HIGH   = 27'd21000101;

    // days before the start of each month in a common year
    localparam logic [8:0] MONTH_START [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // digit split output: year offset, month, day or day number
    typedef struct packed {
        logic [1:0]  mode;
        logic        ok;
        logic [13:0] k;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [18:0] d;
    } t_split_s;

    // year count output: days before the year and leap flags
    typedef struct packed {
        logic [1:0]  mode;
        logic        ok;
        logic [13:0] k;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [18:0] d;
        logic [22:0] dby;
        logic        leap_k;
        logic        leap_km1;
    } t_yday_s;

endpackage

`default_nettype wire

/* hdl/ddn_in_if.sv */
// ddn_in_if: input channel of the date / day number converter
// carries valid, ready, mode and value; no dependencies
`default_nettype none

interface ddn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [26:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

/* hdl/ddn_out_if.sv */
// ddn_out_if: result channel of the date / day number converter
// carries valid, ready, result and valid_res; no dependencies
`default_nettype none

interface ddn_out_if;
    logic        valid;
    logic        ready;
    logic [26:0] result;
    logic        valid_res;

    modport source (output valid, output result, output valid_res, input ready);
    modport sink   (input valid, input result, input valid_res, output ready);
endinterface

`default_nettype wire

/* hdl/ddn_split.sv */
// ddn_split: three stages that split YYYYMMDD into year, month and day and
// divide a day number by 365; depends on ddn_pkg
`default_nettype none

module ddn_split (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_mode,
    input  wire logic [26:0]       i_value,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ddn_pkg::t_split_s      o_data
);

    // stage enables, a stage loads when empty or when it empties downstream
    logic en1, en2, en3;

    logic        r_v1, r_v2, r_v3;
    logic [1:0]  r_mode1, r_mode2;
    logic [26:0] r_val1;
    logic [20:0] r_q100_1, r_q100_2;
    logic [10:0] r_kd1, r_kd2;
    logic        r_rng1, r_rng2;
    logic        r_dok1, r_dok2;
    logic [18:0] r_d1, r_d2;
    logic [6:0]  r_day2;
    logic [13:0] r_year2;
    ddn_pkg::t_split_s r_out3;

    logic [54:0] n_prod100;
    logic [20:0] n_q100;
    logic [38:0] n_prod365;
    logic [10:0] n_kd;
    logic [41:0] n_yprod;
    logic [13:0] n_year;
    logic [6:0]  n_day;
    logic [6:0]  n_month7;
    logic        n_mvalid;
    ddn_pkg::t_split_s n_out;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_data  = r_out3;

    // stage 1: value / 100 and day number / 365 by reciprocal
    assign n_prod100 = 55'(i_value) * 55'(ddn_pkg::RECIP_100_V);
    assign n_q100    = n_prod100[54:34];
    assign n_prod365 = 39'(i_value[18:0]) * 39'(ddn_pkg::RECIP_365);
    assign n_kd      = n_prod365[38:28];

    // stage 2: day digits and year
    assign n_yprod = 42'(r_q100_1) * 42'(ddn_pkg::RECIP_100_Q);
    assign n_year  = n_yprod[41:28];
    assign n_day   = 7'(r_val1 - 27'(r_q100_1) * 27'd100);

    // stage 3: month digits, checks and year offset
    assign n_month7 = 7'(r_q100_2 - 21'(r_year2) * 21'd100);
    assign n_mvalid = (n_month7 >= 7'd1) && (n_month7 <= 7'd12);

    always_comb begin
        n_out.mode  = r_mode2;
        n_out.ok    = 1'b0;
        n_out.k     = 14'(r_year2 - ddn_pkg::EPOCH_YEAR);
        n_out.month = n_mvalid ? n_month7[3:0] : 4'd1;
        n_out.day   = r_day2;
        n_out.d     = r_d2;
        unique case (r_mode2)
            ddn_pkg::MODE_EXACT: begin
                n_out.ok = n_mvalid && (r_year2 >= ddn_pkg::EPOCH_YEAR);
            end
            ddn_pkg::MODE_APPROX: begin
                // bad month falls back to january 1
                n_out.ok = r_rng2;
                if (!n_mvalid) begin
                    n_out.day = 7'd1;
                end
            end
            ddn_pkg::MODE_TO_DATE: begin
                n_out.ok = r_dok2;
                n_out.k  = 14'(r_kd2);
            end
            default: begin
                n_out.ok = 1'b0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_mode1  <= i_mode;
            r_val1   <= i_value;
            r_q100_1 <= n_q100;
            r_kd1    <= n_kd;
            r_rng1   <= (i_value > ddn_pkg::APPROX_LOW) && (i_value < ddn_pkg::APPROX_HIGH);
            r_dok1   <= (i_value[26:19] == 8'd0);
            r_d1     <= i_value[18:0];
        end
        if (en2 && r_v1) begin
            r_mode2  <= r_mode1;
            r_q100_2 <= r_q100_1;
            r_kd2    <= r_kd1;
            r_rng2   <= r_rng1;
            r_dok2   <= r_dok1;
            r_d2     <= r_d1;
            r_day2   <= n_day;
            r_year2  <= n_year;
        end
        if (en3 && r_v2) begin
            r_out3 <= n_out;
        end
    end

endmodule

`default_nettype wire

/* hdl/ddn_yearday.sv */
// ddn_yearday: two stages that count the days before a year and its leap flags
// depends on ddn_pkg
`default_nettype none

module ddn_yearday (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ddn_pkg::t_split_s i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ddn_pkg::t_yday_s       o_data
);

    logic en4, en5;

    logic              r_v4, r_v5;
    ddn_pkg::t_split_s r_s4;
    logic [7:0]        r_kq4;
    logic [22:0]       r_k365_4;
    ddn_pkg::t_yday_s  r_y5;

    logic [28:0] n_kprod;
    logic [7:0]  n_kq;
    logic [22:0] n_k365;
    logic [6:0]  n_r;
    logic        n_c;
    logic [22:0] n_dby;
    ddn_pkg::t_yday_s n_y;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v5;
    assign o_data  = r_y5;

    // stage 4: century count and 365 per year
    assign n_kprod = 29'(i_data.k) * 29'(ddn_pkg::RECIP_100_K);
    assign n_kq    = n_kprod[28:21];
    assign n_k365  = 23'(i_data.k) * 23'd365;

    // stage 5: leap day corrections, leap flags of this and the previous year
    assign n_r   = 7'(r_s4.k - 14'(r_kq4) * 14'd100);
    assign n_c   = (n_r != 7'd0);
    assign n_dby = r_k365_4
                 + 23'((15'(r_s4.k) + 15'd3) >> 2)
                 - 23'(r_kq4) - 23'(n_c)
                 + 23'((9'(r_kq4) + 9'd2 + 9'(n_c)) >> 2);

    always_comb begin
        n_y.mode     = r_s4.mode;
        n_y.ok       = r_s4.ok;
        n_y.k        = r_s4.k;
        n_y.month    = r_s4.month;
        n_y.day      = r_s4.day;
        n_y.d        = r_s4.d;
        n_y.dby      = n_dby;
        // year 1900 + k: divisible by 4, and a century only when its count is 1 mod 4
        n_y.leap_k   = (r_s4.k[1:0] == 2'd0) && (n_c || (r_kq4[1:0] == 2'd1));
        n_y.leap_km1 = (r_s4.k[1:0] == 2'd1) && ((n_r != 7'd1) || (r_kq4[1:0] == 2'd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r_s4     <= i_data;
            r_kq4    <= n_kq;
            r_k365_4 <= n_k365;
        end
        if (en5 && r_v4) begin
            r_y5 <= n_y;
        end
    end

endmodule

`default_nettype wire

/* hdl/ddn_assemble.sv */
// ddn_assemble: three stages that finish the day number, search the month of a
// day of year, build YYYYMMDD and hold the output register; depends on ddn_pkg
`default_nettype none

module ddn_assemble (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ddn_pkg::t_yday_s i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [26:0]           o_result,
    output logic                  o_valid_res
);

    logic en6, en7, en8;

    logic        r_v6, r_v7, r_v8;
    logic [1:0]  r_mode6, r_mode7;
    logic        r_ok6, r_ok7;
    logic [26:0] r_res6, r_res7;
    logic [8:0]  r_doy6;
    logic        r_leap6;
    logic [10:0] r_ky6, r_ky7;
    logic [3:0]  r_month7;
    logic [4:0]  r_dd7;
    logic [26:0] r_result8;
    logic        r_vres8;

    logic [22:0] n_sum;
    logic [23:0] n_diff;
    logic        n_neg;
    logic [8:0]  n_doy;
    logic [10:0] n_ky;
    logic        n_ok;
    logic [3:0]  n_month;
    logic [4:0]  n_dd;
    logic [26:0] n_date;
    logic [26:0] n_result;

    assign en8     = !r_v8 || i_ready;
    assign en7     = !r_v7 || en8;
    assign en6     = !r_v6 || en7;
    assign o_ready = en6;
    assign o_valid = r_v8;
    assign o_result    = r_result8;
    assign o_valid_res = r_vres8;

    // stage 6: day number of a date, and day of year of a day number
    assign n_sum  = i_data.dby + 23'(ddn_pkg::MONTH_START[4'(i_data.month - 4'd1)])
                  + 23'(i_data.day) + 23'(i_data.leap_k && (i_data.month > 4'd2));
    assign n_diff = 24'(i_data.d) - 24'(i_data.dby);
    assign n_neg  = n_diff[23];
    // estimate one year too late: step back a year
    assign n_doy  = n_neg ? 9'(n_diff + 24'd365 + 24'(i_data.leap_km1)) : n_diff[8:0];
    assign n_ky   = n_neg ? 11'(i_data.k - 14'd1) : i_data.k[10:0];

    always_comb begin
        case (i_data.mode) inside
            ddn_pkg::MODE_EXACT, ddn_pkg::MODE_APPROX: n_ok = i_data.ok && (n_sum != 23'd0);
            default:                                   n_ok = i_data.ok;
        endcase
    end

    // stage 7: month search over the twelve month ends
    always_comb begin
        n_month = 4'd12;
        for (int i = 12; i >= 1; i--) begin
            if (10'(r_doy6) < 10'(ddn_pkg::MONTH_START[4'(i)]) + 10'(r_leap6 && (i > 1))) begin
                n_month = 4'(i);
            end
        end
        n_dd = 5'(r_doy6 - (ddn_pkg::MONTH_START[4'(n_month - 4'd1)]
                            + 9'(r_leap6 && (n_month > 4'd2))));
    end

    // stage 8: decimal date and result select
    assign n_date = 27'(r_dd7) + 27'd1 + 27'(r_month7) * 27'd100
                  + (27'(r_ky7) + 27'd1900) * 27'd10000;
    assign n_result = !r_ok7 ? 27'd0 :
                      (r_mode7 == ddn_pkg::MODE_TO_DATE) ? n_date : r_res7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (en6) r_v6 <= i_valid;
            if (en7) r_v7 <= r_v6;
            if (en8) r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6 && i_valid) begin
            r_mode6 <= i_data.mode;
            r_ok6   <= n_ok;
            r_res6  <= 27'(n_sum - 23'd1);
            r_doy6  <= n_doy;
            r_leap6 <= n_neg ? i_data.leap_km1 : i_data.leap_k;
            r_ky6   <= n_ky;
        end
        if (en7 && r_v6) begin
            r_mode7  <= r_mode6;
            r_ok7    <= r_ok6;
            r_res7   <= r_res6;
            r_ky7    <= r_ky6;
            r_month7 <= n_month;
            r_dd7    <= n_dd;
        end
        if (en8 && r_v7) begin
            r_result8 <= n_result;
            r_vres8   <= r_ok7;
        end
    end

endmodule

`default_nettype wire

/* hdl/date_day_number_converter.sv */
// date_day_number_converter: top level of the date / day number converter
// depends on ddn_pkg, ddn_in_if, ddn_out_if, ddn_split, ddn_yearday, ddn_assemble
`default_nettype none

// Converts YYYYMMDD dates to day numbers counted from 1900-01-01 (mode 0 exact,
// mode 1 approximate with january 1 fallback) and day numbers up to 524287 back
// to dates (mode 2); a rejected item gives result 0 with valid_res low. The
// block takes one transfer per cycle while its output is not stalled: three
// stages split the decimal digits by reciprocal multiplication, two count the
// days before the year, and three finish the sum, search the month and hold the
// output register. Each stage has its own valid bit, so a stalled output still
// lets new transfers in until the empty stages are filled.
module date_day_number_converter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ddn_in_if.sink    i_in,
    ddn_out_if.source o_out
);

    logic              s_valid, s_ready;
    ddn_pkg::t_split_s s_data;
    logic              y_valid, y_ready;
    ddn_pkg::t_yday_s  y_data;
    logic              in_ready;

    assign i_in.ready = in_ready;

    // digit split
    ddn_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_mode  (i_in.mode),
        .i_value (i_in.value),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_data  (s_data)
    );

    // days before the year
    ddn_yearday u_yearday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_ready (s_ready),
        .i_data  (s_data),
        .o_valid (y_valid),
        .i_ready (y_ready),
        .o_data  (y_data)
    );

    // final sums, month search and output register
    ddn_assemble u_assemble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (y_valid),
        .o_ready     (y_ready),
        .i_data      (y_data),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_result    (o_out.result),
        .o_valid_res (o_out.valid_res)
    );

    // a rejected conversion always reads as zero
    a_zero_when_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> (o_out.result == 27'd0))
        else $error("rejected result is not zero");

    // split stage holds its item while the year stage is full
    a_split_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("split stage lost or changed a stalled item");

    // year stage holds its item while the assembly stage is full
    a_yday_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (y_valid && !y_ready) |=> (y_valid && $stable(y_data)))
        else $error("year stage lost or changed a stalled item");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for the date / day number converter
// needs ddn_pkg, ddn_in_if, ddn_out_if and date_day_number_converter from hdl/
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int unsigned DAY_LIMIT    = 524287;
    localparam int unsigned VALUE_MAX    = 99999999;
    localparam int          MAX_REPORTS  = 10;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          LONG_HOLD    = 300;
    localparam int          HOLD_AT      = 1400;

    // days before each month in a common year
    localparam int unsigned CUM_DAYS [13] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    typedef struct {
        logic [1:0]  mode;
        logic [26:0] value;
    } t_conv_item;

    typedef struct {
        t_conv_item  src;
        logic [26:0] result;
        logic        ok;
    } t_conv_want;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ddn_in_if  in_ch ();
    ddn_out_if out_ch ();

    date_day_number_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_conv_item pending_items [$];
    t_conv_want expected_conv [$];

    int n_accepted    = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    bit long_hold_done = 1'b0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // calendar arithmetic
    // ---------------------------------------------------------------

    function automatic bit is_leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // days from 1900-01-01 to 1 january of y, y at least 1900
    function automatic int unsigned days_to_jan1(int unsigned y);
        return 365 * (y - 1900) + (y - 1897) / 4 - (y - 1801) / 100 + (y - 1601) / 400;
    endfunction

    // exact YYYYMMDD to day number; day digits run on unchecked
    function automatic int unsigned date_to_day_number(int unsigned v, output bit ok);
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned sum;
        yr = v / 10000;
        mo = (v / 100) % 100;
        dy = v % 100;
        ok = 1'b0;
        if (mo < 1 || mo > 12 || yr < 1900) begin
            return 0;
        end
        sum = days_to_jan1(yr) + CUM_DAYS[mo - 1] + dy;
        if (mo > 2 && is_leap_year(yr)) begin
            sum++;
        end
        // only 1900-01-00 lands before the epoch
        if (sum == 0) begin
            return 0;
        end
        ok = 1'b1;
        return sum - 1;
    endfunction

    function automatic int unsigned day_number_to_date(int unsigned d);
        int unsigned yr;
        int unsigned jan1;
        int unsigned doy;
        int unsigned mo;
        int unsigned lim;
        bit          lp;
        bit          found;
        yr   = 1900 + d / 365;
        jan1 = days_to_jan1(yr);
        // the year estimate can overshoot by one
        if (d < jan1) begin
            yr--;
            doy = d + 365 + (is_leap_year(yr) ? 1 : 0) - jan1;
        end else begin
            doy = d - jan1;
        end
        lp    = is_leap_year(yr);
        mo    = 12;
        found = 1'b0;
        for (int unsigned i = 1; i <= 12; i++) begin
            lim = CUM_DAYS[i] + ((lp && i > 1) ? 1 : 0);
            if (!found && doy < lim) begin
                mo    = i;
                found = 1'b1;
            end
        end
        doy -= CUM_DAYS[mo - 1] + ((lp && mo > 2) ? 1 : 0);
        return (doy + 1) + 100 * mo + 10000 * yr;
    endfunction

    function automatic t_conv_want convert_item(t_conv_item it);
        t_conv_want  w;
        int unsigned v;
        int unsigned mo;
        int unsigned r;
        bit          ok;
        v  = it.value;
        r  = 0;
        ok = 1'b0;
        case (it.mode)
            ddn_pkg::MODE_EXACT: begin
                r = date_to_day_number(v, ok);
            end
            ddn_pkg::MODE_APPROX: begin
                if (v > 19000101 && v < 21000101) begin
                    mo = (v / 100) % 100;
                    // bad month falls back to 1 january of the year
                    if (mo < 1 || mo > 12) begin
                        v = (v / 10000) * 10000 + 101;
                    end
                    r = date_to_day_number(v, ok);
                end
            end
            ddn_pkg::MODE_TO_DATE: begin
                if (v <= DAY_LIMIT) begin
                    r  = day_number_to_date(v);
                    ok = 1'b1;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok) begin
            r = 0;
        end
        w.src    = it;
        w.result = r[26:0];
        w.ok     = ok;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic add_item(logic [1:0] mode, int unsigned value);
        t_conv_item it;
        it.mode  = mode;
        it.value = value[26:0];
        pending_items.push_back(it);
    endtask

    task automatic add_directed();
        // date to days: epoch, the one negative case, bad months, early years
        add_item(ddn_pkg::MODE_EXACT, 19000101);
        add_item(ddn_pkg::MODE_EXACT, 19000100);
        add_item(ddn_pkg::MODE_EXACT, 19000000);
        add_item(ddn_pkg::MODE_EXACT, 18991231);
        add_item(ddn_pkg::MODE_EXACT, 19001301);
        // leap rules around february, day digits past month end
        add_item(ddn_pkg::MODE_EXACT, 19000301);
        add_item(ddn_pkg::MODE_EXACT, 20000229);
        add_item(ddn_pkg::MODE_EXACT, 20000301);
        add_item(ddn_pkg::MODE_EXACT, 99991299);
        add_item(ddn_pkg::MODE_EXACT, VALUE_MAX);
        // approximate: range edges and month fallback
        add_item(ddn_pkg::MODE_APPROX, 19000101);
        add_item(ddn_pkg::MODE_APPROX, 19000102);
        add_item(ddn_pkg::MODE_APPROX, 21000101);
        add_item(ddn_pkg::MODE_APPROX, 21000100);
        add_item(ddn_pkg::MODE_APPROX, 19991399);
        add_item(ddn_pkg::MODE_APPROX, 20000015);
        add_item(ddn_pkg::MODE_APPROX, VALUE_MAX);
        // days to date: year overshoot, limits
        add_item(ddn_pkg::MODE_TO_DATE, 0);
        add_item(ddn_pkg::MODE_TO_DATE, 36500);
        add_item(ddn_pkg::MODE_TO_DATE, 36524);
        add_item(ddn_pkg::MODE_TO_DATE, DAY_LIMIT);
        add_item(ddn_pkg::MODE_TO_DATE, DAY_LIMIT + 1);
        add_item(ddn_pkg::MODE_TO_DATE, VALUE_MAX);
        // unused mode code
        add_item(MODE_UNUSED, VALUE_MAX);
        add_item(MODE_UNUSED, 12345);
    endtask

    task automatic add_random(int n);
        int unsigned sel;
        int unsigned pick;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned d;
        for (int k = 0; k < n; k++) begin
            sel  = $urandom_range(99);
            pick = $urandom_range(9);
            if (sel < 30) begin
                // well-formed dates with occasional bad fields
                yr = (pick == 0) ? $urandom_range(1900, 9999) : $urandom_range(1895, 2405);
                mo = (pick == 2) ? $urandom_range(0, 15) : $urandom_range(1, 12);
                dy = (pick == 1) ? $urandom_range(0, 99) : $urandom_range(0, 31);
                add_item(ddn_pkg::MODE_EXACT, yr * 10000 + mo * 100 + dy);
            end else if (sel < 50) begin
                if (pick < 5) begin
                    add_item(ddn_pkg::MODE_APPROX, $urandom_range(19000102, 21000100));
                end else begin
                    yr = $urandom_range(1900, 2100);
                    mo = (pick == 9) ? $urandom_range(0, 99) : $urandom_range(1, 12);
                    dy = $urandom_range(0, 31);
                    add_item(ddn_pkg::MODE_APPROX, yr * 10000 + mo * 100 + dy);
                end
            end else if (sel < 75) begin
                if (pick == 0) begin
                    add_item(ddn_pkg::MODE_TO_DATE, $urandom_range(DAY_LIMIT + 1, VALUE_MAX));
                end else if (pick < 4) begin
                    // straddle a year boundary
                    d = days_to_jan1($urandom_range(1901, 3335)) + $urandom_range(0, 2) - 1;
                    add_item(ddn_pkg::MODE_TO_DATE, d);
                end else begin
                    add_item(ddn_pkg::MODE_TO_DATE, $urandom_range(0, DAY_LIMIT));
                end
            end else if (sel < 97) begin
                // raw noise on the date modes
                add_item(2'($urandom_range(1)), $urandom_range(0, VALUE_MAX));
            end else begin
                add_item(2'($urandom_range(3)), $urandom_range(0, VALUE_MAX));
            end
        end
    endtask

    // sender pause: nothing left to offer and every result back
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || n_checked != n_accepted) begin
            @(negedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // input driver
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : drive_in
        t_conv_item taken;
        t_conv_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            // log the transfer completing at this edge
            if (in_ch.valid && in_ch.ready) begin
                taken.mode  = in_ch.mode;
                taken.value = in_ch.value;
                expected_conv.push_back(convert_item(taken));
                n_accepted <= n_accepted + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.mode  <= nxt.mode;
                    in_ch.value <= nxt.value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random stalls plus one long hold-off
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!long_hold_done && n_checked >= HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_ch.ready   <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : check_out
        t_conv_want want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (n_checked >= n_accepted) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("unexpected result %0d valid_res %0b",
                             out_ch.result, out_ch.valid_res);
                end
            end else begin
                want = expected_conv.pop_front();
                n_checked <= n_checked + 1;
                if (out_ch.result !== want.result || out_ch.valid_res !== want.ok) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("mode %0d value %0d: expected %0d/%0b, got %0d/%0b",
                                 want.src.mode, want.src.value, want.result, want.ok,
                                 out_ch.result, out_ch.valid_res);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog on cycles with no transfer on either side
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = ddn_pkg::MODE_EXACT;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;

        // sender mostly busy, receiver often stalled
        send_idle_pct = 14;
        recv_idle_pct = 60;
        add_directed();
        add_random(600);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        @(negedge i_clk);
        send_idle_pct = 60;
        recv_idle_pct = 14;
        add_random(600);

        wait_drained();
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(630);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_conv.size() != 0) begin
            n_errors += expected_conv.size();
            $display("%0d results never arrived", expected_conv.size());
        end

        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
